### hdl/polynomial_horner_evaluator_core_macros.svh
// assertion macros used by the checker
`ifndef POLYNOMIAL_HORNER_EVALUATOR_CORE_MACROS_SVH
`define POLYNOMIAL_HORNER_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define PHE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define PHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/phe_pkg.sv
package phe_pkg;

  localparam int NUM_COEFFS = 8;
  localparam int STEP_COUNT = NUM_COEFFS - 1;
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int RND_W      = PROD_W - FRAC_W;
  localparam int SUM_W      = RND_W + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] acc;
    logic                     ovf;
  } phe_word_t;

endpackage

### hdl/phe_in_if.sv
interface phe_in_if;
  import phe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] point_x;

  modport source (output valid, output point_x, input ready);
  modport sink (input valid, input point_x, output ready);
endinterface

### hdl/phe_out_if.sv
interface phe_out_if;
  import phe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value_y;
  logic                     overflow;

  modport source (output valid, output value_y, output overflow, input ready);
  modport sink (input valid, input value_y, input overflow, output ready);
endinterface

### hdl/phe_step.sv
module phe_step
  import phe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] coef,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  phe_word_t                in_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output phe_word_t                out_word
);

  // multiply stage
  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  logic signed [DATA_W-1:0] m_x;
  logic                     m_ovf;
  logic                     m_ready;

  // round, add and saturate stage
  logic                     a_valid;
  phe_word_t                a_word;
  logic                     a_ready;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic signed [RND_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  sum;
  logic                     clamp;
  logic signed [DATA_W-1:0] sat;

  assign a_ready  = !a_valid || out_ready;
  assign m_ready  = !m_valid || a_ready;
  assign in_ready = m_ready;

  assign prod = in_word.acc * in_word.x;

  // floor of (p + half) / 2^16 is round to nearest, ties up
  assign biased  = m_prod + PROD_W'(1 << (FRAC_W - 1));
  assign rounded = biased[PROD_W-1:FRAC_W];
  assign sum     = {rounded[RND_W-1], rounded} + {{(SUM_W - DATA_W){coef[DATA_W-1]}}, coef};
  assign clamp   = sum[SUM_W-1:DATA_W-1] != {(SUM_W - DATA_W + 1){sum[SUM_W-1]}};

  always_comb begin
    if (!clamp) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_prod <= prod;
      m_x    <= in_word.x;
      m_ovf  <= in_word.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && m_valid) begin
      a_word.x   <= m_x;
      a_word.acc <= sat;
      a_word.ovf <= m_ovf || clamp;
    end
  end

  assign out_valid = a_valid;
  assign out_word  = a_word;

endmodule

### hdl/polynomial_horner_evaluator_core.sv
// Horner polynomial evaluator in signed Q16.16: y = c0 + c1*x + ... + c7*x^7.
// Coefficients sit in APB registers coef_0..coef_7 at byte addresses 0x00..0x1c
// and are meant to be written while no point is in flight. Each Horner step is
// a two-stage slice (32x32 multiply, then round-to-nearest, add and saturate),
// and the seven steps are chained, so the block takes one point per cycle
// while the output is not stalled. Every stage has its own valid bit and
// moves whenever the stage after it has room, so bubbles close up under
// output backpressure. overflow reports that any step clamped.
module polynomial_horner_evaluator_core
  import phe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  phe_in_if.sink            sample_in,
  phe_out_if.source         result_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic signed [DATA_W-1:0] coef [REG_COUNT];
  logic [REG_IDX_W-1:0]     reg_idx;

  logic      chain_valid [STEP_COUNT+1];
  logic      chain_ready [STEP_COUNT+1];
  phe_word_t chain_word  [STEP_COUNT+1];

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign prdata  = coef[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        coef[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      coef[reg_idx] <= pwdata;
    end
  end

  // the accumulator starts at the highest coefficient
  assign chain_valid[0]     = sample_in.valid;
  assign sample_in.ready    = chain_ready[0];
  assign chain_word[0].x    = sample_in.point_x;
  assign chain_word[0].acc  = coef[NUM_COEFFS-1];
  assign chain_word[0].ovf  = 1'b0;

  for (genvar k = 0; k < STEP_COUNT; k++) begin : g_step
    phe_step u_step (
      .clk       (clk),
      .rst       (rst),
      .coef      (coef[NUM_COEFFS-2-k]),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_word   (chain_word[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_word  (chain_word[k+1])
    );
  end

  assign result_out.valid         = chain_valid[STEP_COUNT];
  assign chain_ready[STEP_COUNT]  = result_out.ready;
  assign result_out.value_y       = chain_word[STEP_COUNT].acc;
  assign result_out.overflow      = chain_word[STEP_COUNT].ovf;

endmodule

### hdl/phe_checker.sv
`include "polynomial_horner_evaluator_core_macros.svh"

module phe_checker
  import phe_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] value_y,
  input logic              overflow,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata
);

  // a stalled word holds
  `PHE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(value_y) && $stable(overflow))

  // a drained pipeline always takes a point
  `PHE_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // nothing comes out right after reset
  `PHE_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), !out_valid)

  // a register reads back what was just written to it
  `PHE_ASSERT_NOW(a_readback, clk, rst,
    $past(psel && penable && pwrite) && psel && !pwrite && paddr == $past(paddr),
    prdata == $past(pwdata))

endmodule

bind polynomial_horner_evaluator_core phe_checker u_phe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .value_y   (result_out.value_y),
  .overflow  (result_out.overflow),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
